// ===== hw/rtl/aesp_pkg.sv =====
package aesp_pkg;

   // Display command codes
   localparam logic [2:0] CMD_CHAR   = 3'd0;
   localparam logic [2:0] CMD_COL    = 3'd1;
   localparam logic [2:0] CMD_ROWCOL = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_RESET  = 3'd4;
   localparam logic [2:0] CMD_ATTR   = 3'd5;

   // Terminal byte codes
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_ESC      = 8'h1B;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_UPPER_C  = 8'h43;
   localparam logic [7:0] CHAR_UPPER_D  = 8'h44;
   localparam logic [7:0] CHAR_UPPER_H  = 8'h48;
   localparam logic [7:0] CHAR_UPPER_J  = 8'h4A;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
   localparam logic [7:0] CHAR_LOWER_M  = 8'h6D;

   // Parameter values of the recognized sequences
   localparam int ED_CLEAR_ALL  = 2;
   localparam int SGR_RESET     = 0;
   localparam int SGR_BRIGHT    = 1;
   localparam int SGR_FG_FIRST  = 30;
   localparam int SGR_FG_LAST   = 37;
   localparam int ATTR_FG_BASE  = 1;
   localparam int DEC_BASE      = 10;

   // Tab zone width after reset
   localparam logic [7:0] TAB_WIDTH_RESET = 8'd10;

   // Restoring divider: one quotient bit per step over the 8-bit column
   localparam int DIV_STEPS = 8;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_div;
      logic has_rsp;
   } dp_status_type;

endpackage

// ===== hw/rtl/aesp_ctrl.sv =====
module aesp_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  aesp_pkg::dp_status_type  status,
   output aesp_pkg::ctrl_cmd_type   cmd
);

   typedef enum logic [1:0] {
      CS_READY,
      CS_DIV,
      CS_FIN,
      CS_SEND
   } ctrl_state_type;

   localparam logic [aesp_pkg::DIV_CNT_W-1:0] CNT_LAST =
      aesp_pkg::DIV_CNT_W'(aesp_pkg::DIV_STEPS - 1);

   ctrl_state_type                   state_ff, state_in;
   logic [aesp_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // Drive handshake and datapath commands from the state
   assign req_ready      = (state_ff == CS_READY);
   assign rsp_valid      = rsp_valid_ff;
   assign cmd.load       = req_valid && (state_ff == CS_READY);
   assign cmd.div_step   = (state_ff == CS_DIV);
   assign cmd.div_finish = (state_ff == CS_FIN);

   // Next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         CS_READY: begin
            if (req_valid) begin
               if (status.need_div) begin
                  state_in = CS_DIV;
                  cnt_in   = '0;
               end else if (status.has_rsp) begin
                  state_in     = CS_SEND;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         CS_DIV: begin
            if (cnt_ff == CNT_LAST) begin
               state_in = CS_FIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         CS_FIN: begin
            state_in     = CS_SEND;
            rsp_valid_in = 1'b1;
         end
         CS_SEND: begin
            if (rsp_ready) begin
               state_in     = CS_READY;
               rsp_valid_in = 1'b0;
            end
         end
         default: begin
            state_in     = CS_READY;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_READY;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/aesp_dp.sv =====
module aesp_dp #(
   parameter int NUM_BITS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_in_byte,
   input  logic [7:0]               req_cursor_column,
   input  logic                     csr_valid,
   input  logic [7:0]               csr_tab_zone_width,
   input  aesp_pkg::ctrl_cmd_type   cmd,
   output aesp_pkg::dp_status_type  status,
   output logic [2:0]               rsp_command,
   output logic [7:0]               rsp_char_code,
   output logic [7:0]               rsp_target_column,
   output logic [7:0]               rsp_target_row,
   output logic [3:0]               rsp_attribute
);

   localparam int WIDE_W = ((NUM_BITS > 8) ? NUM_BITS : 8) + 1;
   localparam int ACC_W  = NUM_BITS + 5;

   typedef enum logic [2:0] {
      PS_IDLE    = 3'd0,
      PS_ESC     = 3'd1,
      PS_BRACKET = 3'd2,
      PS_FIRST   = 3'd3,
      PS_SECOND  = 3'd4
   } parse_type;

   parse_type             parse_ff, parse_in;
   logic [NUM_BITS-1:0]   first_ff, first_in;
   logic [NUM_BITS-1:0]   second_ff, second_in;
   logic [7:0]            tab_w_ff;

   logic [2:0]            command_ff, res_cmd;
   logic [7:0]            char_ff, res_char;
   logic [7:0]            col_ff, res_col;
   logic [7:0]            row_ff, res_row;
   logic [3:0]            attr_ff, res_attr;

   logic [7:0]            div_rem_ff, div_rem_in;
   logic [7:0]            div_dvd_ff;
   logic [7:0]            div_w_ff;
   logic [7:0]            div_col_ff;
   logic [8:0]            div_shift;
   logic [8:0]            tab_sum;

   logic                  is_digit;
   logic [NUM_BITS-1:0]   digit_val;
   logic [WIDE_W-1:0]     first_w;
   logic [WIDE_W-1:0]     col_w;
   logic [WIDE_W-1:0]     fwd_sum;
   logic [WIDE_W-1:0]     back_diff;
   logic [7:0]            eff_w;

   // Multiply by ten, add a digit, saturate at the accumulator maximum
   function automatic logic [NUM_BITS-1:0] accumulate(
      input logic [NUM_BITS-1:0] acc,
      input logic [NUM_BITS-1:0] d
   );
      logic [ACC_W-1:0] v;
      v = ACC_W'(acc) * ACC_W'(aesp_pkg::DEC_BASE) + ACC_W'(d);
      if (v > ACC_W'({NUM_BITS{1'b1}})) begin
         return {NUM_BITS{1'b1}};
      end
      return v[NUM_BITS-1:0];
   endfunction

   function automatic logic [7:0] sat255(input logic [WIDE_W-1:0] v);
      if (v > WIDE_W'(255)) begin
         return 8'hFF;
      end
      return v[7:0];
   endfunction

   // One-based sequence parameter to zero-based position
   function automatic logic [7:0] minus_one(input logic [NUM_BITS-1:0] v);
      if (v == '0) begin
         return 8'd0;
      end
      return sat255(WIDE_W'(v) - WIDE_W'(1));
   endfunction

   assign is_digit  = (req_in_byte >= aesp_pkg::CHAR_ZERO) &&
                      (req_in_byte <= aesp_pkg::CHAR_NINE);
   assign digit_val = NUM_BITS'(req_in_byte[3:0]);
   assign first_w   = WIDE_W'(first_ff);
   assign col_w     = WIDE_W'(req_cursor_column);
   assign fwd_sum   = col_w + ((first_ff == '0) ? WIDE_W'(1) : first_w);
   assign back_diff = col_w - first_w;
   assign eff_w     = (tab_w_ff == 8'd0) ? 8'd1 : tab_w_ff;

   // Decode the byte against the parse state
   always_comb begin
      parse_in        = parse_ff;
      first_in        = first_ff;
      second_in       = second_ff;
      res_cmd         = aesp_pkg::CMD_CHAR;
      res_char        = 8'd0;
      res_col         = 8'd0;
      res_row         = 8'd0;
      res_attr        = 4'd0;
      status.has_rsp  = 1'b0;
      status.need_div = 1'b0;
      case (parse_ff)
         PS_ESC: begin
            first_in  = '0;
            second_in = '0;
            parse_in  = (req_in_byte == aesp_pkg::CHAR_LBRACKET) ? PS_BRACKET : PS_IDLE;
         end
         PS_BRACKET: begin
            if (req_in_byte == aesp_pkg::CHAR_UPPER_H) begin
               parse_in       = PS_IDLE;
               status.has_rsp = 1'b1;
               res_cmd        = aesp_pkg::CMD_ROWCOL;
            end else if (is_digit) begin
               first_in = digit_val;
               parse_in = PS_FIRST;
            end else begin
               parse_in = PS_IDLE;
            end
         end
         PS_FIRST: begin
            if (is_digit) begin
               first_in = accumulate(first_ff, digit_val);
            end else if (req_in_byte == aesp_pkg::CHAR_SEMI) begin
               second_in = '0;
               parse_in  = PS_SECOND;
            end else begin
               parse_in = PS_IDLE;
               if (req_in_byte == aesp_pkg::CHAR_UPPER_J) begin
                  if (first_w == WIDE_W'(aesp_pkg::ED_CLEAR_ALL)) begin
                     status.has_rsp = 1'b1;
                     res_cmd        = aesp_pkg::CMD_CLEAR;
                  end
               end else if (req_in_byte == aesp_pkg::CHAR_LOWER_M) begin
                  if (first_w == WIDE_W'(aesp_pkg::SGR_RESET)) begin
                     status.has_rsp = 1'b1;
                     res_cmd        = aesp_pkg::CMD_RESET;
                  end else if (first_w == WIDE_W'(aesp_pkg::SGR_BRIGHT)) begin
                     status.has_rsp = 1'b1;
                     res_cmd        = aesp_pkg::CMD_ATTR;
                  end else if ((first_w >= WIDE_W'(aesp_pkg::SGR_FG_FIRST)) &&
                               (first_w <= WIDE_W'(aesp_pkg::SGR_FG_LAST))) begin
                     status.has_rsp = 1'b1;
                     res_cmd        = aesp_pkg::CMD_ATTR;
                     res_attr       = 4'(first_w - WIDE_W'(aesp_pkg::SGR_FG_FIRST) +
                                         WIDE_W'(aesp_pkg::ATTR_FG_BASE));
                  end
               end else if (req_in_byte == aesp_pkg::CHAR_UPPER_C) begin
                  status.has_rsp = 1'b1;
                  res_cmd        = aesp_pkg::CMD_COL;
                  res_col        = sat255(fwd_sum);
               end else if (req_in_byte == aesp_pkg::CHAR_UPPER_D) begin
                  status.has_rsp = 1'b1;
                  res_cmd        = aesp_pkg::CMD_COL;
                  res_col        = (first_w > col_w) ? 8'd0 : back_diff[7:0];
               end
            end
         end
         PS_SECOND: begin
            if ((req_in_byte == aesp_pkg::CHAR_UPPER_H) ||
                (req_in_byte == aesp_pkg::CHAR_LOWER_F)) begin
               parse_in       = PS_IDLE;
               status.has_rsp = 1'b1;
               res_cmd        = aesp_pkg::CMD_ROWCOL;
               res_col        = minus_one(second_ff);
               res_row        = minus_one(first_ff);
            end else if (is_digit) begin
               second_in = accumulate(second_ff, digit_val);
            end
         end
         default: begin
            parse_in = PS_IDLE;
            if (req_in_byte == aesp_pkg::CHAR_ESC) begin
               parse_in = PS_ESC;
            end else if (req_in_byte == aesp_pkg::CHAR_TAB) begin
               status.need_div = 1'b1;
               status.has_rsp  = 1'b1;
               res_cmd         = aesp_pkg::CMD_COL;
            end else begin
               status.has_rsp = 1'b1;
               res_char       = req_in_byte;
            end
         end
      endcase
   end

   // One restoring step of column / zone width, keeping the remainder only
   assign div_shift  = {div_rem_ff, div_dvd_ff[7]};
   assign div_rem_in = (div_shift >= {1'b0, div_w_ff}) ?
                       8'(div_shift - {1'b0, div_w_ff}) : div_shift[7:0];

   // Next zone start: column minus remainder plus width
   assign tab_sum = {1'b0, div_col_ff} - {1'b0, div_rem_ff} + {1'b0, div_w_ff};

   // Advance parse state and accumulators, take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         parse_ff  <= PS_IDLE;
         first_ff  <= '0;
         second_ff <= '0;
         tab_w_ff  <= aesp_pkg::TAB_WIDTH_RESET;
      end else begin
         if (csr_valid) begin
            tab_w_ff <= csr_tab_zone_width;
         end
         if (cmd.load) begin
            parse_ff  <= parse_in;
            first_ff  <= first_in;
            second_ff <= second_in;
         end
      end
   end

   // Capture result fields and run the divider
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= res_cmd;
         char_ff    <= res_char;
         col_ff     <= res_col;
         row_ff     <= res_row;
         attr_ff    <= res_attr;
         div_rem_ff <= 8'd0;
         div_dvd_ff <= req_cursor_column;
         div_col_ff <= req_cursor_column;
         div_w_ff   <= eff_w;
      end
      if (cmd.div_step) begin
         div_rem_ff <= div_rem_in;
         div_dvd_ff <= {div_dvd_ff[6:0], 1'b0};
      end
      if (cmd.div_finish) begin
         col_ff <= sat255(WIDE_W'(tab_sum));
      end
   end

   assign rsp_command       = command_ff;
   assign rsp_char_code     = char_ff;
   assign rsp_target_column = col_ff;
   assign rsp_target_row    = row_ff;
   assign rsp_attribute     = attr_ff;

endmodule

// ===== hw/rtl/ansi_escape_sequence_parser_top.sv =====
// Terminal byte parser for a small VT100/ANSI subset. Each request carries one
// byte and the current cursor column; a byte yields at most one display
// command (write char, set column, set row and column, clear, reset or add an
// attribute). Bytes that only advance the parser return no response. Bytes
// with a response hold rsp_valid until rsp_ready. For TAB the column is
// divided by the tab zone width in an 8-step restoring divider, one quotient
// bit a cycle, before the response is raised. One request is in work at a
// time; the next is taken once the response has been accepted. The tab zone
// width register (reset 10, 0 acts as 1) is to be written through csr_ only
// while no request is in work; the block itself does not enforce this.
// Decimal sequence parameters are NUM_BITS wide and saturate.
module ansi_escape_sequence_parser_top #(
   parameter int NUM_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic [7:0]  req_cursor_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_command,
   output logic [7:0]  rsp_char_code,
   output logic [7:0]  rsp_target_column,
   output logic [7:0]  rsp_target_row,
   output logic [3:0]  rsp_attribute,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_tab_zone_width
);

   aesp_pkg::ctrl_cmd_type   cmd;
   aesp_pkg::dp_status_type  status;

   // Always take register writes
   assign csr_ready = 1'b1;

   aesp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aesp_dp #(
      .NUM_BITS (NUM_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_in_byte        (req_in_byte),
      .req_cursor_column  (req_cursor_column),
      .csr_valid          (csr_valid),
      .csr_tab_zone_width (csr_tab_zone_width),
      .cmd                (cmd),
      .status             (status),
      .rsp_command        (rsp_command),
      .rsp_char_code      (rsp_char_code),
      .rsp_target_column  (rsp_target_column),
      .rsp_target_row     (rsp_target_row),
      .rsp_attribute      (rsp_attribute)
   );

endmodule
